// ----- design/bbc_pkg.sv -----
// Shared types and fixed-point constants for the cascaded band-pass biquad.
// No dependencies; imported by the controller, the datapath and the top level.
package bbc_pkg;

	// Fixed-point formats
	localparam int COEF_W     = 32;  // Q2.30 coefficients
	localparam int SIG_W      = 32;  // section signal, Q9.23
	localparam int SIG_FRAC   = 23;
	localparam int DLY_W      = 40;  // delay registers, 31 fraction bits
	localparam int PROD_W     = 64;  // coef * signal, 53 fraction bits
	localparam int PROD_SHIFT = 22;  // product -> delay format
	localparam int RND_W      = PROD_W - PROD_SHIFT;
	localparam int DLY_SHIFT  = 8;   // delay format -> signal format
	localparam int CFG_IDX_W  = 2;

	localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sd1 <<< (PROD_SHIFT - 1));

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A0 = 2'd0,
		REG_B1 = 2'd1,
		REG_B2 = 2'd2
	} cfg_reg_t;

	// Coefficient feeding the shared multiplier
	typedef enum logic [1:0] {
		MSEL_A0 = 2'd0,
		MSEL_B1 = 2'd1,
		MSEL_B2 = 2'd2
	} mul_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     load_na;
		logic     load_y;
		logic     upd_d1;
		logic     upd_d2;
		logic     load_out;
	} dp_cmd_t;

endpackage

// ----- design/bbc_ctrl.sv -----
// Sequencer for the biquad cascade: steps each section through the shared
// multiplier schedule and owns the input/output handshakes. Uses bbc_pkg.
module bbc_ctrl import bbc_pkg::*; #(
	parameter int STAGES = 4,
	localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output dp_cmd_t          cmd,
	output logic [STG_W-1:0] stage
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL_A = 9'b000000010,
		S_RND   = 9'b000000100,
		S_Y     = 9'b000001000,
		S_B1    = 9'b000010000,
		S_B2    = 9'b000100000,
		S_D1    = 9'b001000000,
		S_D2    = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	localparam logic [STG_W-1:0] LAST_STAGE = STG_W'(STAGES - 1);

	state_t           state_q, state_d;
	logic [STG_W-1:0] stage_q;
	logic             out_valid_q;
	logic             out_free;
	logic             last_stage;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign stage      = stage_q;
	assign out_free   = !out_valid_q || out_ready;
	assign last_stage = (stage_q == LAST_STAGE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_sel = MSEL_A0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MUL_A;
				end
			end
			S_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_A0;
				state_d     = S_RND;
			end
			S_RND: begin
				cmd.load_na = 1'b1;
				state_d     = S_Y;
			end
			S_Y: begin
				cmd.load_y = 1'b1;
				state_d    = S_B1;
			end
			S_B1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_B1;
				state_d     = S_B2;
			end
			S_B2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_B2;
				state_d     = S_D1;
			end
			S_D1: begin
				// start the next section's a0 product alongside the delay update
				cmd.upd_d1  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_A0;
				state_d     = S_D2;
			end
			S_D2: begin
				cmd.upd_d2  = 1'b1;
				cmd.load_na = 1'b1;
				state_d     = last_stage ? S_OUT : S_Y;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, section counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_in) begin
				stage_q <= '0;
			end else if (cmd.upd_d2 && !last_stage) begin
				stage_q <= stage_q + STG_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/bbc_dp.sv -----
// Datapath for the biquad cascade: coefficient registers, shared 32x32
// multiplier, rounding, section delays and output register. Uses bbc_pkg.
module bbc_dp import bbc_pkg::*; #(
	parameter int STAGES       = 4,
	parameter int SAMPLE_WIDTH = 24,
	localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dp_cmd_t                        cmd,
	input  logic [STG_W-1:0]               stage,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [COEF_W-1:0]              cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           block_last,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           block_last_out
);

	// Input and output format conversion
	localparam int IN_SHL   = (SAMPLE_WIDTH <= SIG_FRAC + 1) ? SIG_FRAC + 1 - SAMPLE_WIDTH : 0;
	localparam int IN_SHR   = (SAMPLE_WIDTH > SIG_FRAC + 1) ? SAMPLE_WIDTH - SIG_FRAC - 1 : 0;
	localparam int IN_HALF  = (IN_SHR > 0) ? (1 << (IN_SHR - 1)) : 0;
	localparam int OUT_SHL  = (SAMPLE_WIDTH >= SIG_FRAC + 1) ? SAMPLE_WIDTH - SIG_FRAC - 1 : 0;
	localparam int OUT_SHR  = (SAMPLE_WIDTH < SIG_FRAC + 1) ? SIG_FRAC + 1 - SAMPLE_WIDTH : 0;
	localparam int OUT_HALF = (OUT_SHR > 0) ? (1 << (OUT_SHR - 1)) : 0;
	localparam int OQ_W     = SIG_W + 9;
	localparam int YS_W     = RND_W + 2;            // rounded product + delay
	localparam int DD_W     = RND_W + 1;            // delay update difference
	localparam logic signed [OQ_W-1:0] S_MAX =
		OQ_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [OQ_W-1:0] S_MIN = -S_MAX - OQ_W'(1);
	localparam logic signed [YS_W-1:0] DLY_HALF = YS_W'(1 << (DLY_SHIFT - 1));

	// Clamp a delay update difference to the delay width
	function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [DD_W-1:0] v);
		logic [DD_W-DLY_W:0] top;
		top = v[DD_W-1:DLY_W-1];
		if (top == '0 || top == '1) begin
			sat_dly = v[DLY_W-1:0];
		end else if (v[DD_W-1]) begin
			sat_dly = {1'b1, {(DLY_W-1){1'b0}}};
		end else begin
			sat_dly = {1'b0, {(DLY_W-1){1'b1}}};
		end
	endfunction

	logic signed [COEF_W-1:0] coef_a0_q, coef_b1_q, coef_b2_q;
	logic signed [COEF_W-1:0] mcoef;
	logic signed [PROD_W-1:0] mul_res, prod_q;
	logic signed [PROD_W-1:0] rnd_sum, nrnd_sum;
	logic signed [RND_W-1:0]  rnd_q, na_q;
	logic signed [SIG_W-1:0]  y_q, y_sat, x_conv;
	logic signed [SIG_W:0]    in_ext, in_sum;
	logic signed [YS_W-1:0]   y_sum;
	logic signed [YS_W-DLY_SHIFT-1:0] y_sh;
	logic signed [DD_W-1:0]   d1_diff, d2_diff;
	logic signed [DLY_W-1:0]  d1_q [STAGES];
	logic signed [DLY_W-1:0]  d2_q [STAGES];
	logic signed [OQ_W-1:0]   yo_ext, yo_sum, yo_conv;
	logic signed [SAMPLE_WIDTH-1:0] out_sat;
	logic                     flag_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                     block_last_out_q;

	// Coefficient registers; writes to unused indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a0_q <= '0;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A0:  coef_a0_q <= cfg_data;
				REG_B1:  coef_b1_q <= cfg_data;
				REG_B2:  coef_b2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bring the sample to the section format
	always_comb begin
		in_ext = (SIG_W + 1)'(sample_in);
		in_sum = in_ext + (SIG_W + 1)'(IN_HALF);
		if (IN_SHR == 0) begin
			x_conv = SIG_W'(in_ext <<< IN_SHL);
		end else begin
			x_conv = SIG_W'(in_sum >>> IN_SHR);
		end
	end

	// Shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MSEL_A0: mcoef = coef_a0_q;
			MSEL_B1: mcoef = coef_b1_q;
			MSEL_B2: mcoef = coef_b2_q;
			default: mcoef = coef_a0_q;
		endcase
	end
	assign mul_res = mcoef * y_q;

	// Round the product, and its negation, to the delay format
	assign rnd_sum  = prod_q + PROD_HALF;
	assign nrnd_sum = ~prod_q + PROD_HALF + PROD_W'(1);

	// Section output: rounded a0 product plus first delay, then to signal format
	always_comb begin
		y_sum = YS_W'(rnd_q) + YS_W'(d1_q[stage]) + DLY_HALF;
		y_sh  = y_sum[YS_W-1:DLY_SHIFT];
		if (y_sh[YS_W-DLY_SHIFT-1:SIG_W-1] == '0 || y_sh[YS_W-DLY_SHIFT-1:SIG_W-1] == '1) begin
			y_sat = y_sh[SIG_W-1:0];
		end else if (y_sh[YS_W-DLY_SHIFT-1]) begin
			y_sat = {1'b1, {(SIG_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(SIG_W-1){1'b1}}};
		end
	end

	// Delay updates use the rounded feedback product held in rnd_q
	assign d1_diff = DD_W'(d2_q[stage]) - DD_W'(rnd_q);
	assign d2_diff = DD_W'(na_q) - DD_W'(rnd_q);

	// Arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_res;
		end
		rnd_q <= rnd_sum[PROD_W-1:PROD_SHIFT];
		if (cmd.load_na) begin
			na_q <= nrnd_sum[PROD_W-1:PROD_SHIFT];
		end
		if (cmd.load_in) begin
			y_q    <= x_conv;
			flag_q <= block_last;
		end else if (cmd.load_y) begin
			y_q <= y_sat;
		end
	end

	// Section delays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else begin
			if (cmd.upd_d1) begin
				d1_q[stage] <= sat_dly(d1_diff);
			end
			if (cmd.upd_d2) begin
				d2_q[stage] <= sat_dly(d2_diff);
			end
		end
	end

	// Last section output to sample format, saturated
	always_comb begin
		yo_ext = OQ_W'(y_q);
		yo_sum = yo_ext + OQ_W'(OUT_HALF);
		if (OUT_SHR == 0) begin
			yo_conv = yo_ext <<< OUT_SHL;
		end else begin
			yo_conv = yo_sum >>> OUT_SHR;
		end
		if (yo_conv > S_MAX) begin
			out_sat = S_MAX[SAMPLE_WIDTH-1:0];
		end else if (yo_conv < S_MIN) begin
			out_sat = S_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			out_sat = yo_conv[SAMPLE_WIDTH-1:0];
		end
	end

	// Output register; holds while the beat is stalled
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			sample_out_q     <= out_sat;
			block_last_out_q <= flag_q;
		end
	end

	assign sample_out     = sample_out_q;
	assign block_last_out = block_last_out_q;

endmodule

// ----- design/biquad_bandpass_cascade.sv -----
// out_valid rises once a taken beat has run through all sections into the output register.
// One sample is processed at a time; each section needs three products
// through the single 32x32 multiplier plus rounding, output and delay-update steps.
// The result waits in an output register, so the next beat is taken while it stalls.
// Reset (arst_n low, asynchronous) clears coefficients, all section delays and control.
module biquad_bandpass_cascade import bbc_pkg::*; #(
	parameter int STAGES       = 4,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           block_last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           block_last_out,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [COEF_W-1:0]              cfg_data
);

	localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

	dp_cmd_t          cmd;
	logic [STG_W-1:0] stage;

	bbc_ctrl #(
		.STAGES(STAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.stage    (stage)
	);

	bbc_dp #(
		.STAGES      (STAGES),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stage         (stage),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample_in     (sample_in),
		.block_last    (block_last),
		.sample_out    (sample_out),
		.block_last_out(block_last_out)
	);

endmodule

// ----- design/bbc_checker.sv -----
// Port-level checks for biquad_bandpass_cascade, attached by bind.
// Uses bbc_pkg for the configuration port widths.
module bbc_checker import bbc_pkg::*; #(
	parameter int SAMPLE_WIDTH = 24
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input logic                           block_last_out,
	input logic                           cfg_we,
	input logic [CFG_IDX_W-1:0]           cfg_index,
	input logic [COEF_W-1:0]              cfg_data
);

	logic [1:0] pending_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Track samples taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(block_last_out))
		else $error("stalled output changed");

	// Taking a sample makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready ##1 !in_ready)
		else $error("input taken while busy");

	// A fresh result frees the input side
	a_rose_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while still busy");

	// Results never outrun inputs, and at most two samples are in flight
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != 2'd3) && (!out_valid || pending_q != 2'd0))
		else $error("result count does not match input count");

	// Coefficient writes land only on an empty filter, with known index and data
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> (pending_q == 2'd0) && !$isunknown({cfg_index, cfg_data}))
		else $error("coefficient write while samples in flight");

endmodule

bind biquad_bandpass_cascade bbc_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bbc_checker (.*);

// ----- sim/biquad_bandpass_cascade_tb.sv -----
// Self-checking testbench for the cascaded band-pass biquad filter.
// Depends on bbc_pkg and biquad_bandpass_cascade; a bit-true filter model predicts every sample.
module biquad_bandpass_cascade_tb;
	import bbc_pkg::*;

	localparam int NSEC           = 4;
	localparam int SW             = 24;
	localparam int CLK_PERIOD     = 4;
	localparam int SETTLE         = 5 * NSEC + 4;
	localparam int ITEMS          = 950;
	localparam int HOLD_OFF       = 300;
	localparam int TIMEOUT_CYCLES = 400000;

	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fffffff;
	localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;
	localparam logic signed [COEF_W-1:0] ONE_Q30  = 32'sh40000000;
	// index past the last coefficient; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef enum int {SET_BAND, SET_NEAR, SET_WILD, SET_EDGE} coef_mix_t;

	typedef struct packed {
		logic signed [SW-1:0] sample;
		logic                 last;
	} filt_out_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [SW-1:0]    sample_in;
	logic                    block_last;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SW-1:0]    sample_out;
	logic                    block_last_out;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [COEF_W-1:0]       cfg_data;

	// filter model: coefficients and per-section delay lines
	longint a0_q30, b1_q30, b2_q30;
	longint z1_st [NSEC];
	longint z2_st [NSEC];

	filt_out_t pending_out[$];
	bit        idle_on;
	int        stall_left;
	int        n_sent, n_checked, n_err, n_settings;

	// typical band-pass designs: 1 kHz Q 0.7, 5 kHz Q 2, 200 Hz Q 10 at 48 kHz
	logic signed [COEF_W-1:0] band_a0 [3] = '{32'sd90742000, 32'sd141830000, 32'sd1403000};
	logic signed [COEF_W-1:0] band_b1 [3] = '{-32'sd1949210000, -32'sd1478700000,
		-32'sd2143950000};
	logic signed [COEF_W-1:0] band_b2 [3] = '{32'sd892260000, 32'sd790100000, 32'sd1070940000};

	biquad_bandpass_cascade #(
		.STAGES       (NSEC),
		.SAMPLE_WIDTH (SW)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_in      (sample_in),
		.block_last     (block_last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_out     (sample_out),
		.block_last_out (block_last_out),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// arithmetic right shift with round half up
	function automatic longint rnd_shr(input longint v, input int s);
		if (s == 0) begin
			return v;
		end
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// run one sample through all sections and advance the delay lines
	function automatic logic signed [SW-1:0] filter_sample(input logic signed [SW-1:0] s);
		longint x, y, pa, fb1, fb2, q;
		int i;
		x = longint'(s);
		if (SW <= SIG_FRAC + 1) begin
			x = x <<< (SIG_FRAC + 1 - SW);
		end else begin
			x = rnd_shr(x, SW - SIG_FRAC - 1);
		end
		y = 0;
		for (i = 0; i < NSEC; i++) begin
			pa = x * a0_q30;
			y = clamp(rnd_shr(rnd_shr(pa, PROD_SHIFT) + z1_st[i], DLY_SHIFT), SIG_W);
			fb1 = rnd_shr(b1_q30 * y, PROD_SHIFT);
			fb2 = rnd_shr(b2_q30 * y, PROD_SHIFT);
			z1_st[i] = clamp(z2_st[i] - fb1, DLY_W);
			z2_st[i] = clamp(rnd_shr(-pa, PROD_SHIFT) - fb2, DLY_W);
			x = y;
		end
		if (SW >= SIG_FRAC + 1) begin
			q = y <<< (SW - SIG_FRAC - 1);
		end else begin
			q = rnd_shr(y, SIG_FRAC + 1 - SW);
		end
		q = clamp(q, SW);
		return q[SW-1:0];
	endfunction

	// offer one beat, hold it until taken, then queue its filtered value
	task automatic send_sample(input logic signed [SW-1:0] s, input logic last);
		filt_out_t want;
		while (idle_on && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		sample_in  <= s;
		block_last <= last;
		do @(posedge clk); while (!in_ready);
		want.sample = filter_sample(s);
		want.last   = last;
		pending_out.push_back(want);
		n_sent++;
	endtask

	// drop valid, drain all results and let the last delay update finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_out.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic signed [COEF_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_A0: a0_q30 = longint'(data);
			REG_B1: b1_q30 = longint'(data);
			REG_B2: b2_q30 = longint'(data);
			default: ;
		endcase
	endtask

	task automatic set_coefs(input logic signed [COEF_W-1:0] a0, input logic signed [COEF_W-1:0] b1,
		input logic signed [COEF_W-1:0] b2, input bit stray);
		wait_idle();
		write_reg(REG_A0, a0);
		write_reg(REG_B1, b1);
		write_reg(REG_B2, b2);
		if (stray) begin
			write_reg(REG_SPARE, $urandom());
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic signed [SW-1:0] draw_sample();
		case ($urandom_range(9))
			0, 1, 2, 3: return SW'($urandom());
			4, 5, 6:    return SW'(signed'($urandom()) >>> $urandom_range(23, 8));
			7:          return SAMPLE_MAX;
			8:          return SAMPLE_MIN;
			default:    return '0;
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] edge_coef();
		case ($urandom_range(5))
			0:       return COEF_MAX;
			1:       return COEF_MIN;
			2:       return '0;
			3:       return ONE_Q30;
			4:       return -ONE_Q30;
			default: return $urandom();
		endcase
	endfunction

	// compare each output beat with the oldest prediction
	initial begin
		filt_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_out.size() == 0) begin
					n_err++;
					$display("%0t: unexpected beat, sample_out %0d block_last_out %0b",
						$time, sample_out, block_last_out);
				end else begin
					want = pending_out.pop_front();
					n_checked++;
					if (sample_out !== want.sample) begin
						n_err++;
						$display("%0t: sample_out expected %0d actual %0d",
							$time, want.sample, sample_out);
					end
					if (block_last_out !== want.last) begin
						n_err++;
						$display("%0t: block_last_out expected %0b actual %0b",
							$time, want.last, block_last_out);
					end
				end
			end
		end
	end

	// receiver: random hold-offs, or a counted long stall on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on) begin
				out_ready <= ($urandom_range(99) >= 11);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// reset coefficients are zero, so every sample must come out silent
	task automatic test_reset_coefs();
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample(24'sd1, 1'b0);
	endtask

	// unity gain, then saturating extremes, plus a write to the unused index
	task automatic test_extremes();
		set_coefs(ONE_Q30, '0, '0, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('0, 1'b1);
		send_sample(-24'sd1, 1'b0);
		send_sample(24'sd1, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		set_coefs(COEF_MAX, COEF_MIN, COEF_MAX, 1'b1);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('0, 1'b0);
		set_coefs(COEF_MIN, COEF_MAX, COEF_MIN, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('0, 1'b0);
	endtask

	// hold the output off long enough that the filter stops taking samples
	task automatic test_output_backpressure();
		set_coefs(band_a0[0], band_b1[0], band_b2[0], 1'b0);
		stall_left = HOLD_OFF;
		repeat (40) send_sample(draw_sample(), $urandom_range(15) == 0);
	endtask

	// random coefficient settings, each followed by a burst of samples
	task automatic test_random_settings();
		int phase, pick, count;
		coef_mix_t mix;
		logic signed [COEF_W-1:0] a0, b1, b2;
		phase = 0;
		while (n_sent < ITEMS) begin
			mix = coef_mix_t'($urandom_range(3));
			pick = $urandom_range(2);
			case (mix)
				SET_BAND: begin
					a0 = band_a0[pick];
					b1 = band_b1[pick];
					b2 = band_b2[pick];
				end
				SET_NEAR: begin
					a0 = band_a0[pick] + $urandom_range(4095) - 2048;
					b1 = band_b1[pick] + $urandom_range(4095) - 2048;
					b2 = band_b2[pick] + $urandom_range(4095) - 2048;
				end
				SET_WILD: begin
					a0 = $urandom();
					b1 = $urandom();
					b2 = $urandom();
				end
				default: begin
					a0 = edge_coef();
					b1 = edge_coef();
					b2 = edge_coef();
				end
			endcase
			set_coefs(a0, b1, b2, $urandom_range(3) == 0);
			// one burst runs back to back on both sides
			idle_on = (phase != 1);
			count = $urandom_range(120, 60);
			repeat (count) send_sample(draw_sample(), $urandom_range(15) == 0);
			phase++;
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int i;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample_in  = '0;
		block_last = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		idle_on    = 1'b1;
		stall_left = 0;
		n_sent     = 0;
		n_checked  = 0;
		n_err      = 0;
		n_settings = 0;
		a0_q30     = 0;
		b1_q30     = 0;
		b2_q30     = 0;
		for (i = 0; i < NSEC; i++) begin
			z1_st[i] = 0;
			z2_st[i] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_coefs();
		test_extremes();
		test_output_backpressure();
		test_random_settings();
		wait_idle();

		$display("Filtered %0d samples over %0d coefficient settings, %0d results checked,",
			n_sent, n_settings, n_checked);
		$display("including a %0d-cycle output stall and saturating coefficients; %0d mismatches.",
			HOLD_OFF, n_err);
		if (n_err == 0) begin
			$display("biquad_bandpass_cascade_tb: PASS");
		end else begin
			$display("biquad_bandpass_cascade_tb: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Timeout with %0d results outstanding", pending_out.size());
		$display("biquad_bandpass_cascade_tb: FAIL");
		$finish;
	end

endmodule
